// ----- rtl/dnat44_pkg.sv -----
// Package for the DNAT44 header rewrite block: item types, protocol numbers,
// L4 handling classes and the ones' complement fold helper.
// No dependencies.
package dnat44_pkg;

  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [15:0] CK_ALL_ONES = 16'hffff;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [15:0] ip_checksum;
    logic [31:0] cur_daddr;
    logic [15:0] l4_checksum;
    logic [15:0] port_or_ident;
    logic [31:0] nat_daddr;
    logic [15:0] orig_id;
  } hdr_t;

  typedef struct packed {
    logic [15:0] new_ip_checksum;
    logic [31:0] new_daddr;
    logic [15:0] new_l4_checksum;
    logic [15:0] new_port_or_ident;
  } rw_t;

  // How the L4 checksum and port/identifier are treated
  typedef enum logic [2:0] {
    L4_OTHER,
    L4_TCP,
    L4_UDP,
    L4_UDP_NOCK,
    L4_ICMP
  } l4_kind_t;

  // End-around carry fold of a sum of up to eight 16-bit words
  function automatic logic [15:0] ck_fold(input logic [18:0] s);
    logic [16:0] t;
    logic [16:0] r;
    t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
    r = {1'b0, t[15:0]} + {16'd0, t[16]};
    return r[15:0];
  endfunction

endpackage

// ----- rtl/dnat44_header_rewrite_core.sv -----
// Throughput: one item per cycle while rw is not stalled; four register
// stages (sum, fold, port sum, final fold and select), each advancing
// whenever the next has room.
// Reset: synchronous, clears all stage valid bits; payload is not reset.
// Uses dnat44_pkg.
module dnat44_header_rewrite_core
  import dnat44_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic hdr_valid,
  output logic hdr_ready,
  input  hdr_t hdr,
  output logic rw_valid,
  input  logic rw_ready,
  output rw_t  rw
);

  typedef struct packed {
    l4_kind_t    kind;
    logic [18:0] s_ip;
    logic [18:0] s_l4;
    logic [18:0] s_id;
    logic [15:0] l4_checksum;
    logic [15:0] port_or_ident;
    logic [31:0] nat_daddr;
    logic [15:0] orig_id;
  } st1_t;

  typedef struct packed {
    l4_kind_t    kind;
    logic [15:0] nip;
    logic [15:0] f_l4;
    logic [15:0] icmp_ck;
    logic [15:0] l4_checksum;
    logic [15:0] port_or_ident;
    logic [31:0] nat_daddr;
    logic [15:0] orig_id;
  } st2_t;

  typedef struct packed {
    l4_kind_t    kind;
    logic [15:0] nip;
    logic [17:0] s_port;
    logic [15:0] icmp_ck;
    logic [15:0] l4_checksum;
    logic [15:0] port_or_ident;
    logic [31:0] nat_daddr;
    logic [15:0] orig_id;
  } st3_t;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  st1_t st1, st1_next;
  st2_t st2, st2_next;
  st3_t st3, st3_next;
  rw_t  st4, st4_next;

  // Each stage loads when empty or when its contents move on
  assign en4 = !v4 || rw_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign hdr_ready = en1;
  assign rw_valid  = v4;
  assign rw        = st4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= hdr_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) st1 <= st1_next;
    if (en2) st2 <= st2_next;
    if (en3) st3 <= st3_next;
    if (en4) st4 <= st4_next;
  end

  // Stage 1: classify and form the raw ones' complement sums
  always_comb begin
    logic [18:0] addr_sum;
    addr_sum = {3'd0, ~hdr.cur_daddr[31:16]} + {3'd0, ~hdr.cur_daddr[15:0]}
             + {3'd0, hdr.nat_daddr[31:16]} + {3'd0, hdr.nat_daddr[15:0]};
    st1_next = '0;
    case (hdr.protocol)
      PROTO_TCP:  st1_next.kind = L4_TCP;
      PROTO_UDP:  st1_next.kind = (hdr.l4_checksum == 16'd0) ? L4_UDP_NOCK : L4_UDP;
      PROTO_ICMP: st1_next.kind = L4_ICMP;
      default:    st1_next.kind = L4_OTHER;
    endcase
    st1_next.s_ip = addr_sum + {3'd0, ~hdr.ip_checksum};
    st1_next.s_l4 = addr_sum + {3'd0, ~hdr.l4_checksum};
    st1_next.s_id = {3'd0, ~hdr.l4_checksum} + {3'd0, ~hdr.port_or_ident}
                  + {3'd0, hdr.orig_id};
    st1_next.l4_checksum   = hdr.l4_checksum;
    st1_next.port_or_ident = hdr.port_or_ident;
    st1_next.nat_daddr     = hdr.nat_daddr;
    st1_next.orig_id       = hdr.orig_id;
  end

  // Stage 2: fold; f_l4 is the complement of the address-adjusted checksum
  always_comb begin
    st2_next.kind          = st1.kind;
    st2_next.nip           = ~ck_fold(st1.s_ip);
    st2_next.f_l4          = ck_fold(st1.s_l4);
    st2_next.icmp_ck       = ~ck_fold(st1.s_id);
    st2_next.l4_checksum   = st1.l4_checksum;
    st2_next.port_or_ident = st1.port_or_ident;
    st2_next.nat_daddr     = st1.nat_daddr;
    st2_next.orig_id       = st1.orig_id;
  end

  // Stage 3: add the port change on top of the address adjustment
  always_comb begin
    st3_next.kind          = st2.kind;
    st3_next.nip           = st2.nip;
    st3_next.s_port        = {2'd0, st2.f_l4} + {2'd0, ~st2.port_or_ident}
                           + {2'd0, st2.orig_id};
    st3_next.icmp_ck       = st2.icmp_ck;
    st3_next.l4_checksum   = st2.l4_checksum;
    st3_next.port_or_ident = st2.port_or_ident;
    st3_next.nat_daddr     = st2.nat_daddr;
    st3_next.orig_id       = st2.orig_id;
  end

  // Stage 4: final fold and per-protocol select
  always_comb begin
    logic [15:0] tl4;
    tl4 = ~ck_fold({1'b0, st3.s_port});
    st4_next.new_ip_checksum   = st3.nip;
    st4_next.new_daddr         = st3.nat_daddr;
    st4_next.new_l4_checksum   = st3.l4_checksum;
    st4_next.new_port_or_ident = st3.orig_id;
    case (st3.kind)
      L4_TCP:      st4_next.new_l4_checksum = tl4;
      // a zero UDP checksum means none in use, so map a computed zero
      L4_UDP:      st4_next.new_l4_checksum = (tl4 == 16'd0) ? CK_ALL_ONES : tl4;
      L4_UDP_NOCK: st4_next.new_l4_checksum = st3.l4_checksum;
      L4_ICMP:     st4_next.new_l4_checksum = st3.icmp_ck;
      default:     st4_next.new_port_or_ident = st3.port_or_ident;
    endcase
  end

endmodule

// ----- rtl/dnat44_checker.sv -----
// Port-level checker for dnat44_header_rewrite_core, with its bind.
// Uses dnat44_pkg.
module dnat44_checker
  import dnat44_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic hdr_valid,
  input logic hdr_ready,
  input hdr_t hdr,
  input logic rw_valid,
  input logic rw_ready,
  input rw_t  rw
);

  // Hold a stalled result item
  a_rw_hold: assert property (@(posedge clk) disable iff (rst)
    rw_valid && !rw_ready |=> rw_valid && $stable(rw))
    else $error("stalled result item changed or dropped");

  // Back-pressure only when every stage is full
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !hdr_ready |-> rw_valid && !rw_ready)
    else $error("input stalled while pipeline has room");

  // With output free-flowing, an accepted item appears on rw with its address
  a_latency: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && hdr_ready ##1 rw_ready ##1 rw_ready ##1 rw_ready
    |=> rw_valid && rw.new_daddr == $past(hdr.nat_daddr, 4))
    else $error("result item missing or wrong address after four cycles");

  // Other protocols pass L4 fields through
  a_passthru: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && hdr_ready && hdr.protocol != PROTO_TCP && hdr.protocol != PROTO_UDP
      && hdr.protocol != PROTO_ICMP ##1 rw_ready ##1 rw_ready ##1 rw_ready
    |=> rw.new_port_or_ident == $past(hdr.port_or_ident, 4)
      && rw.new_l4_checksum == $past(hdr.l4_checksum, 4))
    else $error("L4 fields altered for non-TCP/UDP/ICMP item");

endmodule

bind dnat44_header_rewrite_core dnat44_checker u_dnat44_checker (
  .clk       (clk),
  .rst       (rst),
  .hdr_valid (hdr_valid),
  .hdr_ready (hdr_ready),
  .hdr       (hdr),
  .rw_valid  (rw_valid),
  .rw_ready  (rw_ready),
  .rw        (rw)
);
